// File: src/cfr_pkg.sv
// ============================================================================
// cfr_pkg
// Shared types and constants for the checksum frame receiver: parser phases,
// event codes, configuration register indexes and reset values.
// ============================================================================
package cfr_pkg;

    localparam int BYTE_W  = 8;
    localparam int EVENT_W = 3;
    localparam int CFG_IDX_W = 2;

    typedef logic [BYTE_W-1:0]    byte_t;
    typedef logic [EVENT_W-1:0]   event_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Result event codes
    localparam event_t EV_NONE     = 3'd0;
    localparam event_t EV_PAYLOAD  = 3'd1;
    localparam event_t EV_GOOD     = 3'd2;
    localparam event_t EV_CSUM_ERR = 3'd3;
    localparam event_t EV_REJECT   = 3'd4;
    localparam event_t EV_OVERFLOW = 3'd5;

    // Configuration register indexes
    localparam cfg_idx_t REG_RECEIVER_ID   = 2'd0;
    localparam cfg_idx_t REG_FIRST_SOURCE  = 2'd1;
    localparam cfg_idx_t REG_SECOND_SOURCE = 2'd2;
    localparam cfg_idx_t REG_BROADCAST_ID  = 2'd3;

    // Configuration reset values
    localparam byte_t RECEIVER_ID_RST   = 8'd0;
    localparam byte_t FIRST_SOURCE_RST  = 8'd0;
    localparam byte_t SECOND_SOURCE_RST = 8'd0;
    localparam byte_t BROADCAST_ID_RST  = 8'd254;

    // Fixed device identifier that is always accepted
    localparam byte_t DEVICE_ID_ONE = 8'd1;

    // Parser phases, one-hot
    typedef enum logic [6:0] {
        PH_RECEIVER = 7'b0000001,
        PH_SOURCE   = 7'b0000010,
        PH_DEVICE   = 7'b0000100,
        PH_MESSAGE  = 7'b0001000,
        PH_LENGTH   = 7'b0010000,
        PH_PAYLOAD  = 7'b0100000,
        PH_CHECKSUM = 7'b1000000
    } phase_t;

endpackage

// File: src/checksum_frame_receiver_unit.sv
// ============================================================================
// checksum_frame_receiver_unit
// Byte-serial frame parser with an additive modulo-256 checksum. Streams
// payload bytes with their index and reports frame end, header reject and
// payload overflow.
// ============================================================================
//
//  channel | signals                                  | beat
//  --------+------------------------------------------+---------------------------
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data | one register write
//  in      | in_valid/in_ready, rx_byte               | one received byte
//  out     | out_valid/out_ready, event_res ..        | one result per input byte
//
//  One byte is taken per cycle unless out stalls; its result passes through the
//  input register, then parser logic into the result register, before it is offered.
//  cfg_ready is always high; writes are taken whenever offered.
//  A stall on out holds the result register and then the input register;
//  in_ready falls only when both are full and out_ready is low.
//  Reset returns the parser to hunting for the receiver ID and restores the
//  register reset values.
//
module checksum_frame_receiver_unit #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  cfr_pkg::cfg_idx_t cfg_index,
    input  cfr_pkg::byte_t    cfg_data,
    // received bytes
    input  logic              in_valid,
    output logic              in_ready,
    input  cfr_pkg::byte_t    rx_byte,
    // results
    output logic              out_valid,
    input  logic              out_ready,
    output cfr_pkg::event_t   event_res,
    output cfr_pkg::byte_t    payload_byte,
    output cfr_pkg::byte_t    payload_index,
    output cfr_pkg::byte_t    message_id,
    output cfr_pkg::byte_t    sender_id,
    output cfr_pkg::byte_t    target_id,
    output cfr_pkg::byte_t    data_length
);
    import cfr_pkg::*;

    // count plus one needs one bit more than a byte
    localparam logic [BYTE_W:0] MAX_PAYLOAD_C = (BYTE_W+1)'(MAX_PAYLOAD);

    // configuration registers
    byte_t receiver_id_reg;
    byte_t first_source_reg;
    byte_t second_source_reg;
    byte_t broadcast_id_reg;

    // input stage
    logic  in_valid_reg;
    byte_t rx_byte_reg;

    // parser state
    phase_t phase_reg,        phase_next;
    byte_t  sum_reg,          sum_next;
    byte_t  count_reg,        count_next;
    byte_t  length_reg,       length_next;
    byte_t  msg_id_reg,       msg_id_next;
    byte_t  sender_reg,       sender_next;
    byte_t  target_reg,       target_next;

    // result register
    logic   out_valid_reg;
    event_t event_reg,        event_next;
    byte_t  pbyte_reg,        pbyte_next;
    byte_t  pindex_reg,       pindex_next;
    byte_t  msg_out_reg,      msg_out_next;
    byte_t  sender_out_reg,   sender_out_next;
    byte_t  target_out_reg,   target_out_next;
    byte_t  length_out_reg,   length_out_next;

    logic            out_free;
    logic            proc_fire;
    byte_t           sum_add;
    logic [BYTE_W:0] count_inc;
    logic            hdr_out;

    // handshake
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign proc_fire = in_valid_reg && out_free;
    assign in_ready  = !in_valid_reg || out_free;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiver_id_reg   <= RECEIVER_ID_RST;
            first_source_reg  <= FIRST_SOURCE_RST;
            second_source_reg <= SECOND_SOURCE_RST;
            broadcast_id_reg  <= BROADCAST_ID_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RECEIVER_ID:   receiver_id_reg   <= cfg_data;
                REG_FIRST_SOURCE:  first_source_reg  <= cfg_data;
                REG_SECOND_SOURCE: second_source_reg <= cfg_data;
                REG_BROADCAST_ID:  broadcast_id_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rx_byte_reg <= rx_byte;
        end
    end

    // parser: next state and result for the byte in the input register
    assign sum_add   = sum_reg + rx_byte_reg;
    assign count_inc = {1'b0, count_reg} + 1'b1;

    always_comb
    begin
        phase_next  = phase_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        length_next = length_reg;
        msg_id_next = msg_id_reg;
        sender_next = sender_reg;
        target_next = target_reg;
        event_next  = EV_NONE;
        pbyte_next  = '0;
        pindex_next = '0;
        hdr_out     = 1'b0;

        case (phase_reg)
            PH_RECEIVER:
            begin
                if (rx_byte_reg == receiver_id_reg)
                begin
                    sum_next   = rx_byte_reg;
                    phase_next = PH_SOURCE;
                end
            end
            PH_SOURCE:
            begin
                if (rx_byte_reg == first_source_reg || rx_byte_reg == second_source_reg)
                begin
                    sum_next    = sum_add;
                    sender_next = rx_byte_reg;
                    phase_next  = PH_DEVICE;
                end
                else
                begin
                    phase_next = PH_RECEIVER;
                    event_next = EV_REJECT;
                end
            end
            PH_DEVICE:
            begin
                if (rx_byte_reg == DEVICE_ID_ONE || rx_byte_reg == broadcast_id_reg)
                begin
                    sum_next    = sum_add;
                    target_next = rx_byte_reg;
                    phase_next  = PH_MESSAGE;
                end
                else
                begin
                    phase_next = PH_RECEIVER;
                    event_next = EV_REJECT;
                end
            end
            PH_MESSAGE:
            begin
                sum_next    = sum_add;
                msg_id_next = rx_byte_reg;
                phase_next  = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                sum_next    = sum_add;
                length_next = rx_byte_reg;
                count_next  = '0;
                phase_next  = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                sum_next    = sum_add;
                pbyte_next  = rx_byte_reg;
                pindex_next = count_reg;
                hdr_out     = 1'b1;
                count_next  = count_inc[BYTE_W-1:0];
                if (count_inc >= MAX_PAYLOAD_C)
                begin
                    phase_next = PH_RECEIVER;
                    event_next = EV_OVERFLOW;
                end
                else
                begin
                    event_next = EV_PAYLOAD;
                    // a zero length still ends after one payload byte
                    if (count_inc >= {1'b0, length_reg})
                    begin
                        phase_next = PH_CHECKSUM;
                    end
                end
            end
            PH_CHECKSUM:
            begin
                sum_next   = sum_add;
                event_next = (sum_add == '0) ? EV_GOOD : EV_CSUM_ERR;
                hdr_out    = 1'b1;
                phase_next = PH_RECEIVER;
            end
            default:
            begin
                phase_next = PH_RECEIVER;
            end
        endcase

        msg_out_next    = hdr_out ? msg_id_next : '0;
        sender_out_next = hdr_out ? sender_next : '0;
        target_out_next = hdr_out ? target_next : '0;
        length_out_next = hdr_out ? length_next : '0;
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_RECEIVER;
            sum_reg    <= '0;
            count_reg  <= '0;
            length_reg <= '0;
            msg_id_reg <= '0;
            sender_reg <= '0;
            target_reg <= '0;
        end
        else if (proc_fire)
        begin
            phase_reg  <= phase_next;
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            length_reg <= length_next;
            msg_id_reg <= msg_id_next;
            sender_reg <= sender_next;
            target_reg <= target_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire)
        begin
            event_reg      <= event_next;
            pbyte_reg      <= pbyte_next;
            pindex_reg     <= pindex_next;
            msg_out_reg    <= msg_out_next;
            sender_out_reg <= sender_out_next;
            target_out_reg <= target_out_next;
            length_out_reg <= length_out_next;
        end
    end

    // outputs
    assign out_valid     = out_valid_reg;
    assign event_res     = event_reg;
    assign payload_byte  = pbyte_reg;
    assign payload_index = pindex_reg;
    assign message_id    = msg_out_reg;
    assign sender_id     = sender_out_reg;
    assign target_id     = target_out_reg;
    assign data_length   = length_out_reg;

endmodule

// File: verif/checksum_frame_receiver_unit_test.sv
`timescale 1ns / 1ps
// ============================================================================
// checksum_frame_receiver_unit_test
// Self-checking bench for the checksum frame receiver. A short table of
// header, payload and checksum cases runs first. Random frames, broken
// headers and line noise follow under several register settings. Every
// result beat is compared field by field with a behavioural parser model,
// or with a hand-written result for typed directed rows. Both channels idle
// at random, and the rate changes from one phase to the next.
// ============================================================================
module checksum_frame_receiver_unit_test;
    import cfr_pkg::*;

    localparam int MAX_PAYLOAD = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 8;
    localparam int PHASE_BYTES = 310;
    localparam int PRINT_LIMIT = 50;

    // One result beat, field order as on the output ports
    typedef struct packed {
        event_t ev;
        byte_t  pbyte;
        byte_t  pidx;
        byte_t  msg;
        byte_t  src;
        byte_t  dst;
        byte_t  len;
    } frame_result_t;

    // Directed row: byte to send, and a hand-written result where typed is set
    typedef struct packed {
        byte_t         data;
        logic          typed;
        frame_result_t want;
    } stim_row_t;

    localparam frame_result_t NO_RESULT = '0;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    cfg_idx_t cfg_index = REG_RECEIVER_ID;
    byte_t    cfg_data  = '0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    byte_t    rx_byte   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    event_t   event_res;
    byte_t    payload_byte;
    byte_t    payload_index;
    byte_t    message_id;
    byte_t    sender_id;
    byte_t    target_id;
    byte_t    data_length;

    // Shadow registers and parser state of the model
    byte_t  rx_id_reg    = RECEIVER_ID_RST;
    byte_t  src_a_reg    = FIRST_SOURCE_RST;
    byte_t  src_b_reg    = SECOND_SOURCE_RST;
    byte_t  bcast_reg    = BROADCAST_ID_RST;
    phase_t parse_phase  = PH_RECEIVER;
    byte_t  frame_sum    = '0;
    byte_t  payload_seen = '0;
    byte_t  held_len     = '0;
    byte_t  held_msg     = '0;
    byte_t  held_src     = '0;
    byte_t  held_dst     = '0;

    frame_result_t pending_results[$];
    stim_row_t     directed_rows[$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int bytes_sent    = 0;
    int error_count   = 0;
    int cycle_count   = 0;
    int idle_plan[4]  = '{0, 63, 0, 17};
    int stall_plan[4] = '{0, 0, 63, 17};

    checksum_frame_receiver_unit #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_res    (event_res),
        .payload_byte (payload_byte),
        .payload_index(payload_index),
        .message_id   (message_id),
        .sender_id    (sender_id),
        .target_id    (target_id),
        .data_length  (data_length)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // Parser model: advances the state by one byte, returns its result beat
    function automatic frame_result_t parse_byte(byte_t b);
        frame_result_t r;
        logic [8:0]    next_count;
        logic          with_header;
        r           = NO_RESULT;
        with_header = 1'b0;
        case (parse_phase)
            PH_RECEIVER:
            begin
                if (b == rx_id_reg)
                begin
                    frame_sum   = b;
                    parse_phase = PH_SOURCE;
                end
            end
            PH_SOURCE:
            begin
                if (b == src_a_reg || b == src_b_reg)
                begin
                    frame_sum   = frame_sum + b;
                    held_src    = b;
                    parse_phase = PH_DEVICE;
                end
                else
                begin
                    parse_phase = PH_RECEIVER;
                    r.ev        = EV_REJECT;
                end
            end
            PH_DEVICE:
            begin
                if (b == DEVICE_ID_ONE || b == bcast_reg)
                begin
                    frame_sum   = frame_sum + b;
                    held_dst    = b;
                    parse_phase = PH_MESSAGE;
                end
                else
                begin
                    parse_phase = PH_RECEIVER;
                    r.ev        = EV_REJECT;
                end
            end
            PH_MESSAGE:
            begin
                frame_sum   = frame_sum + b;
                held_msg    = b;
                parse_phase = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                frame_sum    = frame_sum + b;
                held_len     = b;
                payload_seen = '0;
                parse_phase  = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                // a zero length still takes one payload byte
                next_count   = {1'b0, payload_seen} + 9'd1;
                frame_sum    = frame_sum + b;
                r.pbyte      = b;
                r.pidx       = payload_seen;
                with_header  = 1'b1;
                payload_seen = next_count[7:0];
                if (next_count >= MAX_PAYLOAD)
                begin
                    parse_phase = PH_RECEIVER;
                    r.ev        = EV_OVERFLOW;
                end
                else
                begin
                    r.ev = EV_PAYLOAD;
                    if (next_count >= {1'b0, held_len})
                        parse_phase = PH_CHECKSUM;
                end
            end
            PH_CHECKSUM:
            begin
                frame_sum   = frame_sum + b;
                r.ev        = (frame_sum == 8'd0) ? EV_GOOD : EV_CSUM_ERR;
                with_header = 1'b1;
                parse_phase = PH_RECEIVER;
            end
            default:
                parse_phase = PH_RECEIVER;
        endcase
        if (with_header)
        begin
            r.msg = held_msg;
            r.src = held_src;
            r.dst = held_dst;
            r.len = held_len;
        end
        return r;
    endfunction

    function automatic frame_result_t result_of(input event_t ev, input byte_t pbyte,
                                                input byte_t pidx, input byte_t msg,
                                                input byte_t src, input byte_t dst,
                                                input byte_t len);
        frame_result_t r;
        r = {ev, pbyte, pidx, msg, src, dst, len};
        return r;
    endfunction

    function automatic void add_row(byte_t data, logic typed, frame_result_t want);
        directed_rows.push_back(stim_row_t'({data, typed, want}));
    endfunction

    // Offer one byte after a random gap; valid stays up between back-to-back beats
    task automatic send_byte(byte_t b, logic typed, frame_result_t want);
        int            gap;
        frame_result_t predicted;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        predicted = parse_byte(b);
        pending_results.push_back(typed ? want : predicted);
        bytes_sent++;
    endtask

    task automatic write_reg(cfg_idx_t idx, byte_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_RECEIVER_ID:   rx_id_reg = val;
            REG_FIRST_SOURCE:  src_a_reg = val;
            REG_SECOND_SOURCE: src_b_reg = val;
            REG_BROADCAST_ID:  bcast_reg = val;
            default: ;
        endcase
    endtask

    task automatic program_regs(byte_t rx_id, byte_t src_a, byte_t src_b, byte_t bcast);
        write_reg(REG_RECEIVER_ID, rx_id);
        write_reg(REG_FIRST_SOURCE, src_a);
        write_reg(REG_SECOND_SOURCE, src_b);
        write_reg(REG_BROADCAST_ID, bcast);
        cfg_valid <= 1'b0;
    endtask

    // Hold the sender until every result beat has come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Well-formed header with random content; checksum mostly correct
    task automatic send_frame();
        byte_t b;
        byte_t tx_sum;
        byte_t len;
        int    roll;
        int    n_payload;
        tx_sum = rx_id_reg;
        send_byte(rx_id_reg, 1'b0, NO_RESULT);
        b      = $urandom_range(1) ? src_a_reg : src_b_reg;
        tx_sum = tx_sum + b;
        send_byte(b, 1'b0, NO_RESULT);
        b      = $urandom_range(1) ? DEVICE_ID_ONE : bcast_reg;
        tx_sum = tx_sum + b;
        send_byte(b, 1'b0, NO_RESULT);
        b      = byte_t'($urandom);
        tx_sum = tx_sum + b;
        send_byte(b, 1'b0, NO_RESULT);
        roll = $urandom_range(99);
        if (roll < 75)
            len = byte_t'($urandom_range(8));
        else if (roll < 92)
            len = byte_t'($urandom_range(MAX_PAYLOAD - 1, 9));
        else
            len = byte_t'($urandom_range(255, MAX_PAYLOAD));
        tx_sum = tx_sum + len;
        send_byte(len, 1'b0, NO_RESULT);
        // overflow ends the frame without a checksum byte
        n_payload = (len == 8'd0) ? 1 : ((len > MAX_PAYLOAD) ? MAX_PAYLOAD : len);
        repeat (n_payload)
        begin
            b      = byte_t'($urandom);
            tx_sum = tx_sum + b;
            send_byte(b, 1'b0, NO_RESULT);
        end
        if (n_payload < MAX_PAYLOAD)
        begin
            b = ($urandom_range(99) < 85) ? byte_t'(8'd0 - tx_sum) : byte_t'($urandom);
            send_byte(b, 1'b0, NO_RESULT);
        end
    endtask

    // Line noise and headers broken at the source or device byte
    task automatic send_noise();
        case ($urandom_range(2))
            0:
            begin
                repeat ($urandom_range(4, 1))
                    send_byte(byte_t'($urandom), 1'b0, NO_RESULT);
            end
            1:
            begin
                send_byte(rx_id_reg, 1'b0, NO_RESULT);
                send_byte(byte_t'($urandom), 1'b0, NO_RESULT);
            end
            default:
            begin
                send_byte(rx_id_reg, 1'b0, NO_RESULT);
                send_byte(src_a_reg, 1'b0, NO_RESULT);
                send_byte(byte_t'($urandom), 1'b0, NO_RESULT);
            end
        endcase
    endtask

    // Result checker
    always @(posedge clk)
    begin : result_check
        frame_result_t got;
        frame_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {event_res, payload_byte, payload_index, message_id,
                   sender_id, target_id, data_length};
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result beat with none pending, event %0d", got.ev));
            else
            begin
                want = pending_results.pop_front();
                if (got.ev != want.ev)
                    report_mismatch($sformatf("event_res %0d, want %0d", got.ev, want.ev));
                if (got.pbyte != want.pbyte)
                    report_mismatch($sformatf("payload_byte %0d, want %0d",
                                              got.pbyte, want.pbyte));
                if (got.pidx != want.pidx)
                    report_mismatch($sformatf("payload_index %0d, want %0d",
                                              got.pidx, want.pidx));
                if (got.msg != want.msg)
                    report_mismatch($sformatf("message_id %0d, want %0d", got.msg, want.msg));
                if (got.src != want.src)
                    report_mismatch($sformatf("sender_id %0d, want %0d", got.src, want.src));
                if (got.dst != want.dst)
                    report_mismatch($sformatf("target_id %0d, want %0d", got.dst, want.dst));
                if (got.len != want.len)
                    report_mismatch($sformatf("data_length %0d, want %0d", got.len, want.len));
            end
        end
    end

    initial
    begin : stimulus
        int phase_end;

        // Directed cases at the reset register values
        // hunting: a byte other than the receiver ID is dropped
        add_row(8'h55, 1'b1, NO_RESULT);
        // bad source ID
        add_row(8'h00, 1'b1, NO_RESULT);
        add_row(8'h07, 1'b1, result_of(EV_REJECT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        // bad device ID
        add_row(8'h00, 1'b1, NO_RESULT);
        add_row(8'h00, 1'b1, NO_RESULT);
        add_row(8'hFF, 1'b1, result_of(EV_REJECT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        // zero length to device one: one payload byte, then a good checksum
        add_row(8'h00, 1'b1, NO_RESULT);
        add_row(8'h00, 1'b1, NO_RESULT);
        add_row(8'h01, 1'b1, NO_RESULT);
        add_row(8'hFF, 1'b1, NO_RESULT);
        add_row(8'h00, 1'b1, NO_RESULT);
        add_row(8'hAB, 1'b1, result_of(EV_PAYLOAD, 8'hAB, 8'h00, 8'hFF, 8'h00, 8'h01, 8'h00));
        add_row(8'h55, 1'b1, result_of(EV_GOOD, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h01, 8'h00));
        // broadcast, two payload bytes, wrong checksum
        add_row(8'h00, 1'b1, NO_RESULT);
        add_row(8'h00, 1'b1, NO_RESULT);
        add_row(8'hFE, 1'b1, NO_RESULT);
        add_row(8'h10, 1'b1, NO_RESULT);
        add_row(8'h02, 1'b1, NO_RESULT);
        add_row(8'hFF, 1'b0, NO_RESULT);
        add_row(8'h80, 1'b0, NO_RESULT);
        add_row(8'h00, 1'b1, result_of(EV_CSUM_ERR, 8'h00, 8'h00, 8'h10, 8'h00, 8'hFE, 8'h02));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);

        // Random frames, one register setting and idling mix per phase
        for (int p = 0; p < 4; p++)
        begin
            wait_for_results();
            case (p)
                0: program_regs(8'hFF, 8'h00, 8'hFF, 8'h00);
                1: program_regs(8'h01, 8'h5A, 8'h5A, DEVICE_ID_ONE);
                default:
                    program_regs(byte_t'($urandom), byte_t'($urandom),
                                 byte_t'($urandom), byte_t'($urandom));
            endcase
            send_idle_pct = idle_plan[p];
            stall_pct     = stall_plan[p];
            phase_end     = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end)
            begin
                if ($urandom_range(99) < 75)
                    send_frame();
                else
                    send_noise();
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
